>>> hw/rtl/masked_route_table_assert.svh
// Assertion macros for the masked route table.
// Expects signals named clk and rst in the scope of each use.
`ifndef MASKED_ROUTE_TABLE_ASSERT_SVH
`define MASKED_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("masked_route_table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("masked_route_table: next-cycle check failed");

`endif

>>> hw/rtl/mrt_pkg.sv
// Shared types and codes for the masked route table.
// No dependencies; imported by masked_route_table and mrt_match.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic ST_STORED = 1'b0;
  localparam logic ST_FULL   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] dest_addr;
    logic [31:0] route_network;
    logic [31:0] route_netmask;
    logic [31:0] route_gateway;
  } req_t;

  typedef struct packed {
    logic        add_status;
    logic [31:0] next_hop;
  } rsp_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] netmask;
    logic [31:0] gateway;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

endpackage

>>> hw/rtl/masked_route_table.sv
// Top level of the masked route table: sequencer, fill count and result register.
// Depends on mrt_pkg, mrt_ram, mrt_match and masked_route_table_assert.svh.
`timescale 1ns / 1ps
`include "masked_route_table_assert.svh"

// Channel  Signals                        Direction  Payload
// req      req_valid, req_ready, req      in         mrt_pkg::req_t
// rsp      rsp_valid, rsp_ready, rsp      out        mrt_pkg::rsp_t
//
// An add beat's status is registered on acceptance and then moves to the output
// register once it is free. A lookup scans the route RAM one entry per cycle
// through its single read port and stops on the first hit or after the last
// filled entry; an empty table is not read at all. Reset clears only the
// fill count and control state; no clearing pass is needed. A stalled rsp holds
// in the output register while the next req beat is already taken and worked on.

module masked_route_table #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mrt_pkg::rsp_t rsp
);
  import mrt_pkg::*;

  // Address width of the route RAM and width of a counter that can hold the
  // entry count itself.
  localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ROUTE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;

  // Routes are never removed, so the valid entries are always entries
  // 0 .. count-1 and the lowest free entry is the entry at count.
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          pend;
  logic [31:0]   dest;
  rsp_t          result;

  logic          req_fire;
  logic          add_write;
  logic          issue;
  logic          hit;
  logic          scan_done;
  logic          load_rsp;
  route_t        wr_route;
  route_t        rd_route;
  logic [ROUTE_W-1:0] rd_bits;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign add_write = req_fire && (req.opcode == OP_ADD) && (count != FULL_COUNT);

  // A read is issued while unscanned valid entries remain; its data comes
  // back in the next cycle and is checked while the next read goes out.
  assign issue = (state == S_SCAN) && (scan_idx < count);

  assign wr_route = '{network: req.route_network,
                      netmask: req.route_netmask,
                      gateway: req.route_gateway};

  mrt_ram #(
    .WIDTH  (ROUTE_W),
    .DEPTH  (ROUTE_ENTRIES),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (add_write),
    .waddr (count[AW-1:0]),
    .wdata (wr_route),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rd_bits)
  );

  assign rd_route = route_t'(rd_bits);

  mrt_match u_match (
    .dest_addr (dest),
    .route     (rd_route),
    .hit       (hit)
  );

  // The scan ends on the first hit, or once every valid entry has been
  // checked without one.
  assign scan_done = (pend && hit) || (!issue && !(pend && !hit));

  // The held result moves to the output register once it is free.
  assign load_rsp = (state == S_HOLD) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = (req.opcode == OP_LOOKUP) ? S_SCAN : S_HOLD;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (add_write) begin
        count <= count + CW'(1);
      end
      pend <= issue;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload and scan registers; these need no reset.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      dest     <= req.dest_addr;
      scan_idx <= '0;
      if (req.opcode == OP_ADD) begin
        result.add_status <= (count == FULL_COUNT) ? ST_FULL : ST_STORED;
        result.next_hop   <= '0;
      end
    end else if (issue) begin
      scan_idx <= scan_idx + CW'(1);
    end
    if ((state == S_SCAN) && scan_done) begin
      result.add_status <= ST_STORED;
      result.next_hop   <= (pend && hit) ? rd_route.gateway : dest;
    end
    if (load_rsp) begin
      rsp <= result;
    end
  end

  `MRT_ASSERT_SAME(a_count_bound, 1'b1, count <= FULL_COUNT)
  `MRT_ASSERT_SAME(a_full_is_full, rsp_valid && (rsp.add_status == ST_FULL),
                   (count == FULL_COUNT) && (rsp.next_hop == 32'd0))
  `MRT_ASSERT_NEXT(a_lookup_scans, req_fire && (req.opcode == OP_LOOKUP), state == S_SCAN)
  `MRT_ASSERT_SAME(a_read_in_range, pend, scan_idx <= count)

endmodule

>>> hw/rtl/mrt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mrt_ram #(
  parameter int WIDTH  = 96,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/mrt_match.sv
// Masked compare unit shared by every step of a lookup scan.
// Depends on mrt_pkg for the route entry type.
`timescale 1ns / 1ps

module mrt_match (
  input  logic [31:0]    dest_addr,
  input  mrt_pkg::route_t route,
  output logic           hit
);
  import mrt_pkg::*;

  // An entry matches when the masked destination equals its network.
  assign hit = ((dest_addr & route.netmask) == route.network);

endmodule

>>> test/tb_masked_route_table.sv
// Self-checking testbench for masked_route_table: adds and lookups on the route table.
// Depends on mrt_pkg and the masked_route_table RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_masked_route_table;
  import mrt_pkg::*;

  localparam int ROUTE_ENTRIES = 16;
  // Timeout for the whole run, set far above the worst case so it leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  // The drain wait covers the longest lookup twice over.
  localparam int DRAIN_CYCLES = 2 * (ROUTE_ENTRIES + 3);
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  masked_route_table #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Request beats waiting to be driven, and the responses they are predicted to produce.
  req_t req_backlog[$];
  rsp_t rsp_due[$];

  // Shadow copy of the route table, updated when a request beat is accepted.
  logic        shadow_valid[ROUTE_ENTRIES];
  logic [31:0] shadow_net[ROUTE_ENTRIES];
  logic [31:0] shadow_mask[ROUTE_ENTRIES];
  logic [31:0] shadow_gw[ROUTE_ENTRIES];

  // Routes the stimulus has queued so far, so lookups can be aimed at real entries.
  logic [31:0] plan_net[ROUTE_ENTRIES];
  logic [31:0] plan_mask[ROUTE_ENTRIES];
  int          plan_count = 0;

  int errors = 0;
  int n_add = 0;
  int n_full = 0;
  int n_lookup = 0;
  int n_hit = 0;
  int rsp_seen = 0;
  int cycles = 0;

  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    for (int k = 0; k < ROUTE_ENTRIES; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_net[k] = '0;
      shadow_mask[k] = '0;
      shadow_gw[k] = '0;
    end
  end

  // Applies one request to the shadow table and returns the response it must produce.
  // An add takes the lowest free entry; a lookup returns the gateway of the first
  // valid entry whose masked destination equals its network, else the destination.
  function automatic rsp_t route_table_step(input req_t r);
    rsp_t res;
    bit   done;
    res = '0;
    done = 1'b0;
    if (r.opcode == OP_ADD) begin
      n_add++;
      res.add_status = ST_FULL;
      for (int k = 0; k < ROUTE_ENTRIES; k++) begin
        if (!done && !shadow_valid[k]) begin
          shadow_valid[k] = 1'b1;
          shadow_net[k] = r.route_network;
          shadow_mask[k] = r.route_netmask;
          shadow_gw[k] = r.route_gateway;
          res.add_status = ST_STORED;
          done = 1'b1;
        end
      end
      if (!done) n_full++;
    end else begin
      n_lookup++;
      res.next_hop = r.dest_addr;
      for (int k = 0; k < ROUTE_ENTRIES; k++) begin
        if (!done && shadow_valid[k] && ((r.dest_addr & shadow_mask[k]) == shadow_net[k])) begin
          res.next_hop = shadow_gw[k];
          done = 1'b1;
        end
      end
      if (done) n_hit++;
    end
    return res;
  endfunction

  // Calm stretches give back-to-back traffic; otherwise each beat draws its own gap.
  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Driver: one beat held on req until accepted, then the drawn gap before the next.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      cycles <= cycles + 1;
      if (req_valid && req_ready) begin
        rsp_due.push_back(route_table_step(req));
      end
      if (req_valid && !req_ready) begin
        // Hold the beat unchanged until the table takes it.
      end else if (send_wait != 0) begin
        req_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (req_backlog.size() != 0) begin
        req <= req_backlog.pop_front();
        req_valid <= 1'b1;
        send_wait <= draw_wait(send_calm);
        if ($urandom_range(0, 49) == 0) send_calm <= ~send_calm;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every response beat against the oldest prediction, then draws
  // how long to keep rsp_ready low before the next one.
  always @(posedge clk) begin : monitor
    rsp_t        want;
    int unsigned w;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen <= rsp_seen + 1;
        if (rsp_due.size() == 0) begin
          $error("response beat with no request outstanding: add_status %0d next_hop %h",
                 rsp.add_status, rsp.next_hop);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          if (rsp.add_status !== want.add_status) begin
            $error("add_status: expected %0d, got %0d", want.add_status, rsp.add_status);
            errors++;
          end
          if (rsp.next_hop !== want.next_hop) begin
            $error("next_hop: expected %h, got %h", want.next_hop, rsp.next_hop);
            errors++;
          end
        end
        w = draw_wait(recv_calm);
        if ($urandom_range(0, 49) == 0) recv_calm <= ~recv_calm;
        recv_wait <= w;
        rsp_ready <= (w == 0) && (hold_left == 0);
      end else if (hold_left != 0) begin
        rsp_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        rsp_ready <= (recv_wait == 1);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Once, mid-run, the receiver stops taking responses for a long stretch while the
  // driver keeps offering beats, so the table backs up and drops req_ready.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding", cycles,
               rsp_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Queues an add; the unused destination field carries random bits.
  task automatic push_add(input logic [31:0] net, input logic [31:0] mask,
                          input logic [31:0] gw);
    req_t r;
    r.opcode = OP_ADD;
    r.dest_addr = $urandom;
    r.route_network = net;
    r.route_netmask = mask;
    r.route_gateway = gw;
    req_backlog.push_back(r);
    if (plan_count < ROUTE_ENTRIES) begin
      plan_net[plan_count] = net;
      plan_mask[plan_count] = mask;
      plan_count++;
    end
  endtask

  // Queues a lookup; the unused route fields carry random bits.
  task automatic push_lookup(input logic [31:0] dst);
    req_t r;
    r.opcode = OP_LOOKUP;
    r.dest_addr = dst;
    r.route_network = $urandom;
    r.route_netmask = $urandom;
    r.route_gateway = $urandom;
    req_backlog.push_back(r);
  endtask

  // Mostly prefix routes of random length, some with arbitrary masks, and some
  // whose network has bits outside the mask so that they can never match.
  task automatic push_random_route();
    logic [31:0] mask;
    logic [31:0] net;
    int          pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) mask = $urandom;
    else mask = 32'hFFFF_FFFF << (32 - $urandom_range(1, 32));
    net = $urandom;
    if (pick != 1) net = net & mask;
    push_add(net, mask, $urandom);
  endtask

  // A lookup aimed inside a known route's network, or a fully random destination.
  task automatic push_random_lookup(input int aim_pct);
    int k;
    if (plan_count != 0 && $urandom_range(0, 99) < aim_pct) begin
      k = $urandom_range(0, plan_count - 1);
      push_lookup((plan_net[k] & plan_mask[k]) | ($urandom & ~plan_mask[k]));
    end else begin
      push_lookup($urandom);
    end
  endtask

  task automatic wait_all_done();
    while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // Directed part: lookups on an empty table miss and return the destination.
    push_lookup(32'h0000_0000);
    push_lookup(32'hFFFF_FFFF);
    push_add(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE);
    push_lookup(32'h0A12_3456);
    push_lookup(32'h0B00_0000);
    // A duplicate route still takes the next free entry.
    push_add(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE);
    // A longer prefix behind a shorter one is shadowed: first match wins.
    push_add(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001);
    push_lookup(32'h0A01_0203);
    // Zero mask with a nonzero network never matches anything.
    push_add(32'h1234_5678, 32'h0000_0000, 32'h5555_5555);
    push_lookup(32'h1234_5678);
    push_lookup(32'h0000_0000);
    // Host route at all ones with an all-zero gateway.
    push_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    push_lookup(32'hFFFF_FFFF);
    push_lookup(32'hFFFF_FFFE);
    // Host route to address zero with an all-ones gateway.
    push_add(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_lookup(32'h0000_0000);
    push_lookup(32'h0000_0001);
    wait_all_done();

    // Random part while the table fills: routes arrive now and then among lookups,
    // and with no default route yet many lookups still miss.
    for (int i = 0; i < 1100; i++) begin
      if (i % 110 == 55 && plan_count < ROUTE_ENTRIES - 1) push_random_route();
      else push_random_lookup(70);
    end
    // The driver pauses here until every response has come back.
    wait_all_done();

    // The last free entry takes a default route: zero mask and zero network
    // match every destination. Every later add finds the table full.
    push_add(32'h0000_0000, 32'h0000_0000, $urandom);
    push_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 620; i++) begin
      if ($urandom_range(0, 9) == 0) push_random_route();
      else push_random_lookup(60);
    end
    wait_all_done();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d adds (%0d refused on a full table) and %0d lookups (%0d hits).",
             n_add, n_full, n_lookup, n_hit);
    $display("Receiver held off for %0d cycles once; run took %0d cycles.", HOLD_CYCLES,
             cycles);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mrt_pkg.sv
hw/rtl/mrt_ram.sv
hw/rtl/mrt_match.sv
hw/rtl/masked_route_table.sv
test/tb_masked_route_table.sv
